### rtl/sgcp_pkg.sv
`default_nettype none
package sgcp_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int FRAC_BITS = 16;

    localparam int COMP_W  = 32;
    localparam int NCOMP   = 6;
    localparam int CELL_W  = NCOMP * COMP_W;
    localparam int ROW_LEN = MAX_WIDTH + 2;
    localparam int COL_W   = $clog2(ROW_LEN);
    localparam int CFG_W_W = 11;
    localparam int CFG_H_W = 16;
    localparam int ROW_W   = CFG_H_W + 1;

    localparam int SUM2_W  = COMP_W + 1;
    localparam int SUM4_W  = COMP_W + 2;
    localparam int PROD_W  = 2 * SUM4_W;
    localparam int DIFF_W  = PROD_W + 1;

    localparam int SHIFT_FACE = FRAC_BITS + 3;
    localparam int SHIFT_EDGE = FRAC_BITS + 2;

    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_TILE_WIDTH  = 1'b0;
    localparam logic REG_TILE_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [COMP_W-1:0] b_z;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_x;
    } t_cell;

    typedef struct packed {
        t_cell prev;
        t_cell older;
    } t_rows;

    typedef struct packed {
        t_cell older;
        t_cell prev;
        t_cell cur;
    } t_col;

    typedef struct packed {
        logic                     restart;
        logic [COL_W-1:0]         w_last;
        logic [ROW_W-1:0]         h_last;
    } t_geom;

    typedef struct packed {
        logic signed [SUM4_W-1:0] ay4x;
        logic signed [SUM4_W-1:0] by4x;
        logic signed [SUM2_W-1:0] az2x;
        logic signed [SUM2_W-1:0] bz2x;
        logic signed [SUM4_W-1:0] ax4y;
        logic signed [SUM4_W-1:0] bx4y;
        logic signed [SUM2_W-1:0] az2y;
        logic signed [SUM2_W-1:0] bz2y;
        logic signed [SUM2_W-1:0] ax2z;
        logic signed [SUM2_W-1:0] bx2z;
        logic signed [SUM2_W-1:0] ay2z;
        logic signed [SUM2_W-1:0] by2z;
        logic                     last;
    } t_sums;

    function automatic logic signed [SUM2_W-1:0] sum2(
        input logic signed [COMP_W-1:0] a,
        input logic signed [COMP_W-1:0] b
    );
        return SUM2_W'(a) + SUM2_W'(b);
    endfunction

    function automatic logic signed [SUM4_W-1:0] sum4(
        input logic signed [COMP_W-1:0] a,
        input logic signed [COMP_W-1:0] b,
        input logic signed [COMP_W-1:0] c,
        input logic signed [COMP_W-1:0] d
    );
        return SUM4_W'(a) + SUM4_W'(b) + SUM4_W'(c) + SUM4_W'(d);
    endfunction

endpackage
`default_nettype wire

### rtl/staggered_grid_cross_product_core.sv
`default_nettype none
// Channel  Side    Word                                   Handshake
// s_axis   in      tdata: a_x a_y a_z b_x b_y b_z         tvalid / tready
// m_axis   out     tdata: cross_x cross_y cross_z, tlast  tvalid / tready
// apb      config  tile_width @0x0, tile_height @0x4      psel / penable, pready high
//
// One word per cycle is taken unless m_axis back-pressure stalls; each result is registered in s1, s2, p, d and o.
// The row store is read as a cell is taken and written as the cell leaves s1, one entry per column.
// Reset clears positions and stage valids; row stores and window are not cleared.
// Stage valids fill bubbles, so words are taken while a result waits on m_axis.
module staggered_grid_cross_product_core import sgcp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CELL_W-1:0]     s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*COMP_W-1:0]   m_axis_tdata,   // cross_x, cross_y, cross_z
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    logic [CFG_W_W-1:0] r_tile_width;
    logic [CFG_H_W-1:0] r_tile_height;
    logic               cfg_wr;
    t_geom              geom;

    logic               win_valid;
    logic               win_ready;
    t_sums              win_sums;

    logic signed [COMP_W-1:0] cross_x;
    logic signed [COMP_W-1:0] cross_y;
    logic signed [COMP_W-1:0] cross_z;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width  <= CFG_W_W'(64);
            r_tile_height <= CFG_H_W'(64);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TILE_WIDTH:  r_tile_width  <= pwdata[CFG_W_W-1:0];
                REG_TILE_HEIGHT: r_tile_height <= pwdata[CFG_H_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TILE_WIDTH:  prdata = DATA_W'(r_tile_width);
            REG_TILE_HEIGHT: prdata = DATA_W'(r_tile_height);
        endcase
    end

    always_comb begin
        geom.restart = cfg_wr;
        if (r_tile_width == '0) begin
            geom.w_last = COL_W'(2);
        end else if (32'(r_tile_width) > 32'(MAX_WIDTH)) begin
            geom.w_last = COL_W'(MAX_WIDTH + 1);
        end else begin
            geom.w_last = COL_W'(r_tile_width) + COL_W'(1);
        end
        if (r_tile_height == '0) begin
            geom.h_last = ROW_W'(2);
        end else begin
            geom.h_last = ROW_W'(r_tile_height) + ROW_W'(1);
        end
    end

    sgcp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cell  (t_cell'(s_axis_tdata)),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_sums  (win_sums)
    );

    sgcp_cross u_cross (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (win_valid),
        .o_ready   (win_ready),
        .i_sums    (win_sums),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_cross_x (cross_x),
        .o_cross_y (cross_y),
        .o_cross_z (cross_z),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {cross_z, cross_y, cross_x};

endmodule
`default_nettype wire

### rtl/sgcp_window.sv
`default_nettype none
module sgcp_window import sgcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_geom i_geom,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cell i_cell,
    output logic  o_valid,
    input  logic  i_ready,
    output t_sums o_sums
);

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;

    t_rows mem [ROW_LEN];
    t_rows r_rd_q;

    logic             r_s1_v;
    t_cell            r_s1_cell;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_emit;
    logic             r_s1_last;

    t_col  r_win0;
    t_col  r_win1;
    t_col  fresh;

    logic  r_s2_v;
    t_sums r_s2;
    t_sums n_s2;

    logic accept;
    logic s1_go;
    logic s1_fire;
    logic col_end;
    logic cell_last;

    assign s1_go     = !r_s2_v || i_ready;
    assign s1_fire   = r_s1_v && s1_go;
    assign o_ready   = !r_s1_v || s1_go;
    assign accept    = i_valid && o_ready;
    assign col_end   = (r_col == i_geom.w_last);
    assign cell_last = col_end && (r_row == i_geom.h_last);

    always_comb begin
        if (cell_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_end) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_geom.restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_ready) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cell <= i_cell;
            r_s1_col  <= r_col;
            r_s1_emit <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_s1_last <= cell_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_q <= mem[r_col];
        end
        if (s1_fire) begin
            mem[r_s1_col] <= t_rows'{prev: r_s1_cell, older: r_rd_q.prev};
        end
    end

    always_comb begin
        fresh.older = r_rd_q.older;
        fresh.prev  = r_rd_q.prev;
        fresh.cur   = r_s1_cell;
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win0 <= r_win1;
            r_win1 <= fresh;
        end
    end

    always_comb begin
        n_s2.ay4x = sum4(r_win1.prev.a_y, fresh.prev.a_y, r_win1.older.a_y, fresh.older.a_y);
        n_s2.by4x = sum4(r_win1.prev.b_y, fresh.prev.b_y, r_win1.older.b_y, fresh.older.b_y);
        n_s2.az2x = sum2(r_win1.prev.a_z, r_win1.older.a_z);
        n_s2.bz2x = sum2(r_win1.prev.b_z, r_win1.older.b_z);
        n_s2.ax4y = sum4(r_win1.prev.a_x, r_win0.prev.a_x, r_win1.cur.a_x, r_win0.cur.a_x);
        n_s2.bx4y = sum4(r_win1.prev.b_x, r_win0.prev.b_x, r_win1.cur.b_x, r_win0.cur.b_x);
        n_s2.az2y = sum2(r_win1.prev.a_z, r_win0.prev.a_z);
        n_s2.bz2y = sum2(r_win1.prev.b_z, r_win0.prev.b_z);
        n_s2.ax2z = sum2(r_win1.prev.a_x, r_win1.cur.a_x);
        n_s2.bx2z = sum2(r_win1.prev.b_x, r_win1.cur.b_x);
        n_s2.ay2z = sum2(r_win1.prev.a_y, fresh.prev.a_y);
        n_s2.by2z = sum2(r_win1.prev.b_y, fresh.prev.b_y);
        n_s2.last = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_s2_v <= 1'b1;
        end else if (i_ready) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_v;
    assign o_sums  = r_s2;

endmodule
`default_nettype wire

### rtl/sgcp_cross.sv
`default_nettype none
module sgcp_cross import sgcp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_sums                    i_sums,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [COMP_W-1:0] o_cross_x,
    output logic signed [COMP_W-1:0] o_cross_y,
    output logic signed [COMP_W-1:0] o_cross_z,
    output logic                     o_last
);

    localparam logic signed [DIFF_W:0] SAT_HI = (DIFF_W+1)'(2**(COMP_W-1) - 1);
    localparam logic signed [DIFF_W:0] SAT_LO = -SAT_HI - (DIFF_W+1)'(1);

    function automatic logic signed [COMP_W-1:0] round_sat(
        input logic signed [DIFF_W-1:0] v,
        input int                       s
    );
        logic signed [DIFF_W:0] t;
        logic signed [DIFF_W:0] q;
        t = (DIFF_W+1)'(v) + ((DIFF_W+1)'(1) <<< (s - 1));
        q = t >>> s;
        if (q > SAT_HI) begin
            return COMP_W'(SAT_HI);
        end else if (q < SAT_LO) begin
            return COMP_W'(SAT_LO);
        end
        return COMP_W'(q);
    endfunction

    logic r_p_v;
    logic r_d_v;
    logic r_o_v;
    logic go_p;
    logic go_d;
    logic go_o;

    logic signed [PROD_W-1:0] r_px1;
    logic signed [PROD_W-1:0] r_px2;
    logic signed [PROD_W-1:0] r_py1;
    logic signed [PROD_W-1:0] r_py2;
    logic signed [PROD_W-1:0] r_pz1;
    logic signed [PROD_W-1:0] r_pz2;
    logic                     r_p_last;

    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [DIFF_W-1:0] r_dz;
    logic                     r_d_last;

    logic signed [COMP_W-1:0] r_cx;
    logic signed [COMP_W-1:0] r_cy;
    logic signed [COMP_W-1:0] r_cz;
    logic                     r_o_last;

    logic signed [SUM4_W-1:0] az2x;
    logic signed [SUM4_W-1:0] bz2x;
    logic signed [SUM4_W-1:0] az2y;
    logic signed [SUM4_W-1:0] bz2y;
    logic signed [SUM4_W-1:0] ax2z;
    logic signed [SUM4_W-1:0] bx2z;
    logic signed [SUM4_W-1:0] ay2z;
    logic signed [SUM4_W-1:0] by2z;

    assign go_o    = !r_o_v || i_ready;
    assign go_d    = !r_d_v || go_o;
    assign go_p    = !r_p_v || go_d;
    assign o_ready = go_p;

    assign az2x = SUM4_W'(i_sums.az2x);
    assign bz2x = SUM4_W'(i_sums.bz2x);
    assign az2y = SUM4_W'(i_sums.az2y);
    assign bz2y = SUM4_W'(i_sums.bz2y);
    assign ax2z = SUM4_W'(i_sums.ax2z);
    assign bx2z = SUM4_W'(i_sums.bx2z);
    assign ay2z = SUM4_W'(i_sums.ay2z);
    assign by2z = SUM4_W'(i_sums.by2z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (go_p) begin
                r_p_v <= i_valid;
            end
            if (go_d) begin
                r_d_v <= r_p_v;
            end
            if (go_o) begin
                r_o_v <= r_d_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go_p && i_valid) begin
            r_px1    <= i_sums.ay4x * bz2x;
            r_px2    <= az2x * i_sums.by4x;
            r_py1    <= az2y * i_sums.bx4y;
            r_py2    <= i_sums.ax4y * bz2y;
            r_pz1    <= ax2z * by2z;
            r_pz2    <= ay2z * bx2z;
            r_p_last <= i_sums.last;
        end
        if (go_d && r_p_v) begin
            r_dx     <= DIFF_W'(r_px1) - DIFF_W'(r_px2);
            r_dy     <= DIFF_W'(r_py1) - DIFF_W'(r_py2);
            r_dz     <= DIFF_W'(r_pz1) - DIFF_W'(r_pz2);
            r_d_last <= r_p_last;
        end
        if (go_o && r_d_v) begin
            r_cx     <= round_sat(r_dx, SHIFT_FACE);
            r_cy     <= round_sat(r_dy, SHIFT_FACE);
            r_cz     <= round_sat(r_dz, SHIFT_EDGE);
            r_o_last <= r_d_last;
        end
    end

    assign o_valid   = r_o_v;
    assign o_cross_x = r_cx;
    assign o_cross_y = r_cy;
    assign o_cross_z = r_cz;
    assign o_last    = r_o_last;

endmodule
`default_nettype wire

### bench/sgcp_checker.sv
`timescale 1ns / 100ps
module sgcp_checker import sgcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cell_valid,
    input  logic                 i_cell_ready,
    input  logic [CELL_W-1:0]    i_cell_data,    // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [3*COMP_W-1:0]  i_res_data,     // cross_x, cross_y, cross_z
    input  logic                 i_res_last,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [PADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]    i_pwdata,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int AX = 0;
    localparam int AY = 1;
    localparam int AZ = 2;
    localparam int BX = 3;
    localparam int BY = 4;
    localparam int BZ = 5;

    typedef struct {
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
        logic              last_flag;
    } t_cross_word;

    t_cross_word        cross_q [$];
    longint             prev_row  [ROW_LEN][NCOMP];
    longint             older_row [ROW_LEN][NCOMP];
    longint             win       [2][3][NCOMP];
    longint             nbhd      [3][3][NCOMP];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;

    function automatic longint at(input int dx, input int dy, input int k);
        return nbhd[dx + 1][dy + 1][k];
    endfunction

    function automatic logic [COMP_W-1:0] cross_term(
        input longint p,
        input longint q,
        input longint r,
        input longint t,
        input int     s
    );
        logic signed [71:0] pp;
        logic signed [71:0] qq;
        logic signed [71:0] rr;
        logic signed [71:0] tt;
        logic signed [71:0] d;
        logic signed [71:0] half;
        pp = p;
        qq = q;
        rr = r;
        tt = t;
        half = 72'sd1 <<< (s - 1);
        d = ((pp * qq - rr * tt) + half) >>> s;
        if (d > 72'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (d < -72'sd2147483648) begin
            return 32'h8000_0000;
        end
        return d[COMP_W-1:0];
    endfunction

    task automatic take_cell(input t_cell c);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        longint      fresh [3][NCOMP];
        longint      comp  [NCOMP];
        logic        emit;
        logic        last;
        t_cross_word r;
        comp[AX] = longint'(c.a_x);
        comp[AY] = longint'(c.a_y);
        comp[AZ] = longint'(c.a_z);
        comp[BX] = longint'(c.b_x);
        comp[BY] = longint'(c.b_y);
        comp[BZ] = longint'(c.b_z);
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        col = col_pos;
        row = row_pos;
        if (col > w + 1) begin
            col = 0;
        end
        for (int k = 0; k < NCOMP; k++) begin
            fresh[0][k] = older_row[col][k];
            fresh[1][k] = prev_row[col][k];
            fresh[2][k] = comp[k];
            older_row[col][k] = prev_row[col][k];
            prev_row[col][k] = comp[k];
        end
        emit = (col >= 2) && (row >= 2);
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < NCOMP; k++) begin
                if (emit) begin
                    nbhd[0][j][k] = win[0][j][k];
                    nbhd[1][j][k] = win[1][j][k];
                    nbhd[2][j][k] = fresh[j][k];
                end
                win[0][j][k] = win[1][j][k];
                win[1][j][k] = fresh[j][k];
            end
        end
        last = (col == w + 1) && (row == h + 1);
        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end else if (col == w + 1) begin
            col_pos = 0;
            row_pos = row + 1;
        end else begin
            col_pos = col + 1;
            row_pos = row;
        end
        if (emit) begin
            r.x = cross_term(at(0, 0, AY) + at(1, 0, AY) + at(0, -1, AY) + at(1, -1, AY),
                             at(0, 0, BZ) + at(0, -1, BZ),
                             at(0, 0, AZ) + at(0, -1, AZ),
                             at(0, 0, BY) + at(1, 0, BY) + at(0, -1, BY) + at(1, -1, BY),
                             SHIFT_FACE);
            r.y = cross_term(at(0, 0, AZ) + at(-1, 0, AZ),
                             at(0, 0, BX) + at(-1, 0, BX) + at(0, 1, BX) + at(-1, 1, BX),
                             at(0, 0, AX) + at(-1, 0, AX) + at(0, 1, AX) + at(-1, 1, AX),
                             at(0, 0, BZ) + at(-1, 0, BZ),
                             SHIFT_FACE);
            r.z = cross_term(at(0, 0, AX) + at(0, 1, AX),
                             at(0, 0, BY) + at(1, 0, BY),
                             at(0, 0, AY) + at(1, 0, AY),
                             at(0, 0, BX) + at(0, 1, BX),
                             SHIFT_EDGE);
            r.last_flag = last;
            cross_q.push_back(r);
        end
    endtask

    task automatic check_result();
        t_cross_word e;
        if (cross_q.size() == 0) begin
            $error("result word arrived with no cross product pending");
            o_errors++;
        end else begin
            e = cross_q.pop_front();
            if (i_res_data[COMP_W-1:0] !== e.x) begin
                $error("cross_x expected %h actual %h", e.x, i_res_data[COMP_W-1:0]);
                o_errors++;
            end
            if (i_res_data[2*COMP_W-1:COMP_W] !== e.y) begin
                $error("cross_y expected %h actual %h", e.y, i_res_data[2*COMP_W-1:COMP_W]);
                o_errors++;
            end
            if (i_res_data[3*COMP_W-1:2*COMP_W] !== e.z) begin
                $error("cross_z expected %h actual %h", e.z,
                       i_res_data[3*COMP_W-1:2*COMP_W]);
                o_errors++;
            end
            if (i_res_last !== e.last_flag) begin
                $error("last_cell expected %b actual %b", e.last_flag, i_res_last);
                o_errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cross_q.delete();
            width_reg = CFG_W_W'(64);
            height_reg = CFG_H_W'(64);
            col_pos = 0;
            row_pos = 0;
            o_errors = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[PADDR_W-1:2] == REG_TILE_WIDTH) begin
                    width_reg = i_pwdata[CFG_W_W-1:0];
                end else if (i_paddr[PADDR_W-1:2] == REG_TILE_HEIGHT) begin
                    height_reg = i_pwdata[CFG_H_W-1:0];
                end
                col_pos = 0;
                row_pos = 0;
            end
            if (i_cell_valid && i_cell_ready) begin
                take_cell(t_cell'(i_cell_data));
            end
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
        end
        o_pending = cross_q.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import sgcp_pkg::*;

    typedef enum int {MODE_EXTREME, MODE_TINY, MODE_MIXED} t_fill_mode;

    localparam logic [PADDR_W-1:0] ADDR_WIDTH  = PADDR_W'({REG_TILE_WIDTH, 2'b00});
    localparam logic [PADDR_W-1:0] ADDR_HEIGHT = PADDR_W'({REG_TILE_HEIGHT, 2'b00});

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [CELL_W-1:0]   s_axis_tdata = '0;   // a_x, a_y, a_z, b_x, b_y, b_z
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [3*COMP_W-1:0] m_axis_tdata;        // cross_x, cross_y, cross_z
    logic                m_axis_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int src_idle = 37;
    int snk_idle = 77;
    int tile_cols;
    int tile_rows;
    int chk_errors;
    int chk_pending;

    staggered_grid_cross_product_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sgcp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (s_axis_tvalid),
        .i_cell_ready (s_axis_tready),
        .i_cell_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_last   (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [COMP_W-1:0] pick_comp(input t_fill_mode mode);
        logic [COMP_W-1:0] v;
        case (mode)
            MODE_EXTREME: begin
                v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            MODE_TINY: begin
                case ($urandom_range(3))
                    0: v = '1;
                    1: v = 32'd1;
                    2: v = 32'h0000_8000;
                    default: v = 32'hFFFF_8000;
                endcase
            end
            default: begin
                case ($urandom_range(7))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = '0;
                    3, 4: v = $urandom_range(524287) - 262144;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (chk_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Upper pwdata bits are random; only the register field must take effect.
    task automatic configure(input int w, input int h);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(negedge i_clk);
        apb_write(ADDR_WIDTH, (DATA_W'($urandom) & ~DATA_W'(32'h7FF)) | DATA_W'(w));
        @(negedge i_clk);
        apb_write(ADDR_HEIGHT, (DATA_W'($urandom) & ~DATA_W'(32'hFFFF)) | DATA_W'(h));
        tile_cols = ((w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w)) + 2;
        tile_rows = ((h == 0) ? 1 : h) + 2;
    endtask

    task automatic send_cells(input t_fill_mode mode, input int count, input int pause_at);
        t_cell c;
        for (int i = 0; i < count; i++) begin
            c.a_x = pick_comp(mode);
            c.a_y = pick_comp(mode);
            c.a_z = pick_comp(mode);
            c.b_x = pick_comp(mode);
            c.b_y = pick_comp(mode);
            c.b_z = pick_comp(mode);
            if (i == pause_at || $urandom_range(63) == 0) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            while ($urandom_range(99) < src_idle) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= c;
            do @(posedge i_clk); while (!s_axis_tready);
            @(negedge i_clk);
        end
    endtask

    initial begin
        int phase_items;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        configure(0, 0);
        send_cells(MODE_EXTREME, tile_cols * tile_rows, -1);
        send_cells(MODE_TINY, tile_cols * tile_rows, -1);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 37 : ((ph == 1) ? 77 : 0);
            snk_idle = (ph == 0) ? 77 : ((ph == 1) ? 37 : 0);
            phase_items = 0;
            while (phase_items < 100) begin
                if (phase_items == 0 || $urandom_range(2) == 0) begin
                    configure(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 6),
                              ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4));
                end
                send_cells(MODE_MIXED, tile_cols * tile_rows,
                           (ph == 0 && phase_items == 0) ? tile_cols * 2 : -1);
                phase_items += tile_cols * tile_rows;
            end
        end

        // Wide tiles cut short: the next register write restarts the raster.
        configure(MAX_WIDTH, 1);
        send_cells(MODE_MIXED, 30, -1);
        configure(2047, 1);
        send_cells(MODE_MIXED, 30, -1);

        // Tall tile cut short: the next register write restarts the raster.
        configure(1, 65535);
        send_cells(MODE_MIXED, 60, -1);
        configure(3, 2);
        send_cells(MODE_MIXED, tile_cols * tile_rows, -1);
        send_cells(MODE_MIXED, tile_cols * tile_rows, -1);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/sgcp_pkg.sv
rtl/sgcp_window.sv
rtl/sgcp_cross.sv
rtl/staggered_grid_cross_product_core.sv
bench/sgcp_checker.sv
bench/testbench.sv
